[rtl/pdfc_pkg.sv]
// Shared types and constants for the PWM duty and frequency capture block.
package pdfc_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 16;
  localparam int CAP_W               = 16;
  localparam int TIME_W              = 16;
  localparam int TICK_W              = 7;
  localparam int PERIOD_W            = TIME_W + 1;
  localparam int NUM_W               = 23;
  localparam int REM_W               = PERIOD_W + 1;
  localparam int DIV_STEPS           = NUM_W;
  localparam int STEP_W              = $clog2(DIV_STEPS);
  localparam int DUTY_W              = 7;
  localparam int FREQ_W              = 20;
  localparam int QUEUE_DEPTH         = 2;
  localparam int QPTR_W              = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W              = $clog2(QUEUE_DEPTH + 1);

  localparam logic [TICK_W-1:0] TICK_RESET       = 7'd4;
  localparam logic              FIRST_EDGE_RESET = 1'b1;
  localparam logic [NUM_W-1:0]  DUTY_SCALE       = 23'd100;
  localparam logic [NUM_W-1:0]  US_PER_SECOND    = 23'd1000000;

  typedef enum logic [0:0] {
    CFG_FIRST_EDGE = 1'b0,
    CFG_TICK_US    = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_OUT
  } back_state_t;

  typedef struct packed {
    logic              cap_edge;
    logic [TIME_W-1:0] high_time;
    logic [TIME_W-1:0] low_time;
  } entry_t;

endpackage

[rtl/pwm_duty_frequency_capture.sv]
// Top level of the PWM duty and frequency capture block.
// Each accepted capture is written into the queue; the back end then pops it into its
// registers, runs the bit-serial restoring dividers (duty and frequency run side by side)
// and holds the result in the result register until the output is ready. The back end
// takes no new item until its result has been taken, but the front end takes a capture
// whenever the two-item queue is not full, so it keeps accepting while the dividers are
// busy or the result waits.
module pwm_duty_frequency_capture #(
  parameter int COUNT_WIDTH = pdfc_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [pdfc_pkg::TICK_W-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pdfc_pkg::CAP_W-1:0]    in_capture_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_captured_edge,
  output logic [pdfc_pkg::TIME_W-1:0]   out_high_time_us,
  output logic [pdfc_pkg::TIME_W-1:0]   out_low_time_us,
  output logic [pdfc_pkg::DUTY_W-1:0]   out_duty_percent,
  output logic [pdfc_pkg::FREQ_W-1:0]   out_frequency_hz,
  output logic                          out_period_zero
);

  logic             q_push, q_pop, q_full, q_empty;
  pdfc_pkg::entry_t push_entry, pop_entry;

  pdfc_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_capture_value (in_capture_value),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_entry          (push_entry)
  );

  pdfc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .full       (q_full),
    .empty      (q_empty)
  );

  pdfc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_entry           (pop_entry),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_captured_edge (out_captured_edge),
    .out_high_time_us  (out_high_time_us),
    .out_low_time_us   (out_low_time_us),
    .out_duty_percent  (out_duty_percent),
    .out_frequency_hz  (out_frequency_hz),
    .out_period_zero   (out_period_zero)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("item pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("item popped from empty queue");

  a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !q_empty)
    else $error("accepted item missing from queue");

  a_zero_period: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_period_zero) |->
      (out_duty_percent == '0 && out_frequency_hz == '0))
    else $error("zero period with non-zero duty or frequency");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_duty_percent <= 7'd100))
    else $error("duty above 100 percent");

endmodule

[rtl/pdfc_front.sv]
// Front end: configuration, edge tracking and high/low time update per capture.
module pdfc_front #(
  parameter int COUNT_WIDTH = pdfc_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [pdfc_pkg::TICK_W-1:0]  cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pdfc_pkg::CAP_W-1:0]   in_capture_value,
  input  logic                         q_full,
  output logic                         q_push,
  output pdfc_pkg::entry_t             q_entry
);

  localparam int DW = (COUNT_WIDTH < pdfc_pkg::CAP_W) ? COUNT_WIDTH : pdfc_pkg::CAP_W;
  localparam int PW = DW + pdfc_pkg::TICK_W;

  logic                           expect_r, expect_nxt;
  logic [pdfc_pkg::TICK_W-1:0]    tick_r, tick_nxt;
  logic [DW-1:0]                  prev_r, prev_nxt;
  logic [pdfc_pkg::TIME_W-1:0]    high_r, high_nxt;
  logic [pdfc_pkg::TIME_W-1:0]    low_r, low_nxt;
  logic [DW-1:0]                  diff;
  logic [PW-1:0]                  prod;
  logic [pdfc_pkg::TIME_W-1:0]    span;
  logic                           accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  assign diff = in_capture_value[DW-1:0] - prev_r;
  assign prod = PW'(diff) * PW'(tick_r);
  assign span = pdfc_pkg::TIME_W'(prod);

  always_comb begin
    expect_nxt = expect_r;
    tick_nxt   = tick_r;
    prev_nxt   = prev_r;
    high_nxt   = high_r;
    low_nxt    = low_r;
    if (cfg_we) begin
      case (cfg_index)
        pdfc_pkg::CFG_FIRST_EDGE: expect_nxt = cfg_wdata[0];
        pdfc_pkg::CFG_TICK_US:    tick_nxt   = cfg_wdata;
        default: ;
      endcase
    end
    if (accept) begin
      expect_nxt = !expect_r;
      prev_nxt   = in_capture_value[DW-1:0];
      if (expect_r) begin
        low_nxt = span;
      end else begin
        high_nxt = span;
      end
    end
  end

  assign q_entry.cap_edge  = expect_r;
  assign q_entry.high_time = expect_r ? high_r : span;
  assign q_entry.low_time  = expect_r ? span : low_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_r <= pdfc_pkg::FIRST_EDGE_RESET;
      tick_r   <= pdfc_pkg::TICK_RESET;
      prev_r   <= '0;
      high_r   <= '0;
      low_r    <= '0;
    end else begin
      expect_r <= expect_nxt;
      tick_r   <= tick_nxt;
      prev_r   <= prev_nxt;
      high_r   <= high_nxt;
      low_r    <= low_nxt;
    end
  end

endmodule

[rtl/pdfc_queue.sv]
// Short item queue between the front end and the divider back end.
module pdfc_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  pdfc_pkg::entry_t              push_entry,
  input  logic                          pop,
  output pdfc_pkg::entry_t              pop_entry,
  output logic                          full,
  output logic                          empty
);

  pdfc_pkg::entry_t                 mem_r [pdfc_pkg::QUEUE_DEPTH];
  logic [pdfc_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [pdfc_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [pdfc_pkg::QCNT_W-1:0]      count_r, count_nxt;

  assign full      = (count_r == pdfc_pkg::QCNT_W'(pdfc_pkg::QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign pop_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == pdfc_pkg::QPTR_W'(pdfc_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == pdfc_pkg::QPTR_W'(pdfc_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[rtl/pdfc_back.sv]
// Back end: two lockstep restoring dividers for duty and frequency, result register.
module pdfc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  pdfc_pkg::entry_t              q_entry,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_captured_edge,
  output logic [pdfc_pkg::TIME_W-1:0]   out_high_time_us,
  output logic [pdfc_pkg::TIME_W-1:0]   out_low_time_us,
  output logic [pdfc_pkg::DUTY_W-1:0]   out_duty_percent,
  output logic [pdfc_pkg::FREQ_W-1:0]   out_frequency_hz,
  output logic                          out_period_zero
);

  pdfc_pkg::back_state_t           state_r, state_nxt;
  logic [pdfc_pkg::STEP_W-1:0]     cnt_r;
  logic [pdfc_pkg::NUM_W-1:0]      num_d_r, num_f_r;
  logic [pdfc_pkg::REM_W-1:0]      rem_d_r, rem_f_r;
  logic [pdfc_pkg::PERIOD_W-1:0]   div_r;
  pdfc_pkg::entry_t                item_r;
  logic                            zero_r;

  logic                            load, step, last;
  logic [pdfc_pkg::REM_W-1:0]      trial_d, trial_f, div_ext;
  logic                            ge_d, ge_f;
  logic [pdfc_pkg::PERIOD_W-1:0]   period;

  assign last    = (cnt_r == pdfc_pkg::STEP_W'(pdfc_pkg::DIV_STEPS - 1));
  assign period  = pdfc_pkg::PERIOD_W'(q_entry.high_time)
                 + pdfc_pkg::PERIOD_W'(q_entry.low_time);
  assign div_ext = pdfc_pkg::REM_W'(div_r);
  assign trial_d = {rem_d_r[pdfc_pkg::REM_W-2:0], num_d_r[pdfc_pkg::NUM_W-1]};
  assign trial_f = {rem_f_r[pdfc_pkg::REM_W-2:0], num_f_r[pdfc_pkg::NUM_W-1]};
  assign ge_d    = (trial_d >= div_ext);
  assign ge_f    = (trial_f >= div_ext);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pdfc_pkg::BK_IDLE: if (!q_empty) state_nxt = pdfc_pkg::BK_DIV;
      pdfc_pkg::BK_DIV:  if (last) state_nxt = pdfc_pkg::BK_OUT;
      pdfc_pkg::BK_OUT:  if (out_ready) state_nxt = pdfc_pkg::BK_IDLE;
      default:           state_nxt = pdfc_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    load      = 1'b0;
    step      = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      pdfc_pkg::BK_IDLE: load = !q_empty;
      pdfc_pkg::BK_DIV:  step = 1'b1;
      pdfc_pkg::BK_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

  assign q_pop = load;

  assign out_captured_edge = item_r.cap_edge;
  assign out_high_time_us  = item_r.high_time;
  assign out_low_time_us   = item_r.low_time;
  assign out_period_zero   = zero_r;
  assign out_duty_percent  = zero_r ? '0 : num_d_r[pdfc_pkg::DUTY_W-1:0];
  assign out_frequency_hz  = zero_r ? '0 : num_f_r[pdfc_pkg::FREQ_W-1:0];

  always_ff @(posedge clk) begin
    if (load) begin
      item_r  <= q_entry;
      div_r   <= period;
      zero_r  <= (period == '0);
      num_d_r <= pdfc_pkg::NUM_W'(q_entry.high_time) * pdfc_pkg::DUTY_SCALE;
      num_f_r <= pdfc_pkg::US_PER_SECOND;
      rem_d_r <= '0;
      rem_f_r <= '0;
      cnt_r   <= '0;
    end else if (step) begin
      num_d_r <= {num_d_r[pdfc_pkg::NUM_W-2:0], ge_d};
      num_f_r <= {num_f_r[pdfc_pkg::NUM_W-2:0], ge_f};
      rem_d_r <= ge_d ? trial_d - div_ext : trial_d;
      rem_f_r <= ge_f ? trial_f - div_ext : trial_f;
      cnt_r   <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pdfc_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
